// ===== hw/rtl/c8ic_pkg.sv =====
// ----------------------------------------------------------------------------
// c8ic_pkg: shared constants for the CHIP-8 instruction core
// Field widths, stream packing widths, request codes and the built-in font.
// ----------------------------------------------------------------------------
`default_nettype none

package c8ic_pkg;

    localparam int MEM_BYTES      = 4096;
    localparam int ADDR_W         = 12;
    localparam int SCREEN_COLUMNS = 64;
    localparam int SCREEN_ROWS    = 32;
    localparam int KEY_COUNT      = 16;
    localparam int FONT_BYTES     = 80;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 96;

    localparam logic [11:0] PC_RESET = 12'h200;

    // request codes
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_EXEC = 2'd1;
    localparam logic [1:0] FUNC_ROW  = 2'd2;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
        8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
        8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
        8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
        8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
        8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
        8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
        8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
        8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80
    };

    typedef logic [7:0] byte_t;

endpackage

`default_nettype wire

// ===== hw/rtl/chip8_instruction_core.sv =====
// ----------------------------------------------------------------------------
// chip8_instruction_core: CHIP-8 interpreter driven one request at a time
// Loads program bytes, executes single instructions, returns screen rows.
// ----------------------------------------------------------------------------
// Usage:
//   s_ side carries one request per handshake: a program byte load, a single
//   instruction execute, or a screen row read. m_ side returns exactly one
//   result per request: PC, executed word, redraw, sound, halt, key wait and
//   the selected row.
//   Each request walks the states in order. A load, a row read, an unused
//   code or an execute while halted goes straight to the done state. An
//   execute fetches the two opcode bytes, runs the exec state, then any
//   RET, FX33, FX55, FX65 or DXYN states, and commits; an unknown opcode
//   skips the commit. One shared 17-bit add/sub unit and the single memory
//   port serve these steps; one request is in work at a time, and the next
//   one is accepted the cycle after the result is loaded.
//   Reset: the font is written at 0..79 and the rest of memory cleared by a
//   pass over all 4096 bytes, one byte per cycle; s_tready stays low meanwhile.
//   Registers, stack, timers, halt and the frame buffer clear at once.
//   Stall: a finished result sits in the output register until taken; the
//   next request is accepted meanwhile, and its result waits for the slot.
`default_nettype none

module chip8_instruction_core #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: func[1:0], load_address[13:2], load_byte[21:14],
    // keys_pressed[37:22], waited_key[41:38], waited_key_valid[42],
    // random_byte[50:43], row_select[55:51]
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [c8ic_pkg::S_DATA_W-1:0]  s_tdata,
    // m_tdata: next_address[11:0], executed_word[27:12], redraw[28],
    // sound_on[29], halted[30], waiting_for_key[31], row_pixels[95:32]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [c8ic_pkg::M_DATA_W-1:0]       m_tdata
);
    import c8ic_pkg::*;

    localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam logic [4:0] ST_CLR    = 5'd0;
    localparam logic [4:0] ST_IDLE   = 5'd1;
    localparam logic [4:0] ST_F0     = 5'd2;
    localparam logic [4:0] ST_F1     = 5'd3;
    localparam logic [4:0] ST_F2     = 5'd4;
    localparam logic [4:0] ST_EXEC   = 5'd5;
    localparam logic [4:0] ST_RET    = 5'd6;
    localparam logic [4:0] ST_BCD_H  = 5'd7;
    localparam logic [4:0] ST_BCD_T  = 5'd8;
    localparam logic [4:0] ST_BCD_O  = 5'd9;
    localparam logic [4:0] ST_ST55   = 5'd10;
    localparam logic [4:0] ST_LD_A   = 5'd11;
    localparam logic [4:0] ST_LD_D   = 5'd12;
    localparam logic [4:0] ST_DR_A   = 5'd13;
    localparam logic [4:0] ST_DR_D   = 5'd14;
    localparam logic [4:0] ST_DR_PX  = 5'd15;
    localparam logic [4:0] ST_COMMIT = 5'd16;
    localparam logic [4:0] ST_DONE   = 5'd17;

    // request fields
    logic [1:0]  s_func;
    logic [11:0] s_load_address;
    logic [7:0]  s_load_byte;
    logic [4:0]  s_row_select;
    assign s_func         = s_tdata[1:0];
    assign s_load_address = s_tdata[13:2];
    assign s_load_byte    = s_tdata[21:14];
    assign s_row_select   = s_tdata[55:51];

    logic [4:0]  state_reg, state_next;
    logic [11:0] clr_cnt_reg;
    logic        accept;

    // latched request fields
    logic [15:0] keys_reg;
    logic [3:0]  wkey_reg;
    logic        wkey_vld_reg;
    logic [7:0]  rnd_reg;

    // architectural state
    byte_t       v_reg [16];
    logic [15:0] i_reg;
    logic [11:0] pc_reg, next_pc_reg;
    logic [SP_W-1:0] sp_reg;
    logic [7:0]  dly_reg, snd_reg;
    logic [SCREEN_COLUMNS-1:0] fb_reg [SCREEN_ROWS];
    logic        halt_reg;

    // stack memory with per-entry valid bits
    logic [11:0] stk_mem [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] stk_vld_reg;
    logic [11:0] stk_q_reg;
    logic        stk_hit_reg;
    logic [SP_W-1:0] sp_inc, sp_dec;

    // main memory port
    byte_t       mem [MEM_BYTES];
    logic        mem_we;
    logic [11:0] mem_wa, mem_ra;
    byte_t       mem_wd, mem_q_reg;

    // per-request work registers
    logic [15:0] op_reg;
    logic [15:0] word_reg;
    logic        redraw_reg, wait_reg;
    logic [SCREEN_COLUMNS-1:0] row_out_reg;
    logic [3:0]  loop_cnt_reg;
    logic [2:0]  px_reg;
    logic [3:0]  digit_reg;
    logic [7:0]  bcd_val_reg;
    byte_t       sprite_reg;
    logic        hit_reg;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    // shared add/sub unit
    logic [15:0] alu_a, alu_b;
    logic        alu_sub;
    logic [16:0] alu_res;
    assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + 17'(alu_sub);

    // opcode fields
    logic [3:0]  op_nib, op_x, op_y, op_n;
    logic [7:0]  op_kk, vx, vy;
    logic [11:0] op_nnn, pc_plus2, pc_plus4;
    assign op_nib   = op_reg[15:12];
    assign op_x     = op_reg[11:8];
    assign op_y     = op_reg[7:4];
    assign op_n     = op_reg[3:0];
    assign op_kk    = op_reg[7:0];
    assign op_nnn   = op_reg[11:0];
    assign vx       = v_reg[op_x];
    assign vy       = v_reg[op_y];
    assign pc_plus2 = pc_reg + 12'd2;
    assign pc_plus4 = pc_reg + 12'd4;

    assign sp_inc = (sp_reg == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;
    assign sp_dec = (sp_reg == '0) ? SP_W'(STACK_DEPTH - 1) : sp_reg - 1'b1;

    // draw pixel address
    logic [8:0]  row_base;
    logic [8:0]  col_base;
    logic [15:0] pix;
    logic        pix_on, pix_in;
    logic [4:0]  pix_row;
    logic [5:0]  pix_bit;
    assign row_base = {1'b0, vy} + 9'(loop_cnt_reg);
    assign col_base = {1'b0, vx} + 9'(px_reg);
    assign pix      = alu_res[15:0];
    assign pix_in   = (pix[15:11] == 5'd0);
    assign pix_row  = pix[10:6];
    assign pix_bit  = ~pix[5:0];
    assign pix_on   = sprite_reg[~px_reg];

    logic key_down;
    assign key_down = (vx < 8'(KEY_COUNT)) && keys_reg[vx[3:0]];

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // operand select for the shared unit
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_EXEC: begin
                case (op_nib)
                    4'h7: begin
                        alu_a = 16'(vx);
                        alu_b = 16'(op_kk);
                    end
                    4'h8: begin
                        alu_a   = (op_n == 4'h7) ? 16'(vy) : 16'(vx);
                        alu_b   = (op_n == 4'h7) ? 16'(vx) : 16'(vy);
                        alu_sub = (op_n == 4'h5) || (op_n == 4'h7);
                    end
                    4'hF: begin
                        alu_a = i_reg;
                        alu_b = 16'(vx);
                    end
                    default: begin
                        alu_a = '0;
                    end
                endcase
            end
            ST_BCD_H: begin
                alu_a   = 16'(bcd_val_reg);
                alu_b   = 16'd100;
                alu_sub = 1'b1;
            end
            ST_BCD_T: begin
                alu_a   = 16'(bcd_val_reg);
                alu_b   = 16'd10;
                alu_sub = 1'b1;
            end
            ST_DR_PX: begin
                alu_a = {1'b0, row_base, 6'b0};
                alu_b = 16'(col_base);
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    // memory port control
    always_comb begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        mem_ra = '0;
        case (state_reg)
            ST_CLR: begin
                mem_we = 1'b1;
                mem_wa = clr_cnt_reg;
                mem_wd = (clr_cnt_reg < 12'(FONT_BYTES)) ? FONT_ROM[clr_cnt_reg[6:0]] : 8'h00;
            end
            ST_IDLE: begin
                mem_we = accept && (s_func == FUNC_LOAD);
                mem_wa = s_load_address;
                mem_wd = s_load_byte;
            end
            ST_F0:   mem_ra = pc_reg;
            ST_F1:   mem_ra = pc_reg + 12'd1;
            ST_BCD_H: begin
                mem_we = !alu_res[16];
                mem_wa = i_reg[11:0];
                mem_wd = 8'(digit_reg);
            end
            ST_BCD_T: begin
                mem_we = !alu_res[16];
                mem_wa = i_reg[11:0] + 12'd1;
                mem_wd = 8'(digit_reg);
            end
            ST_BCD_O: begin
                mem_we = 1'b1;
                mem_wa = i_reg[11:0] + 12'd2;
                mem_wd = bcd_val_reg;
            end
            ST_ST55: begin
                mem_we = 1'b1;
                mem_wa = i_reg[11:0] + 12'(loop_cnt_reg);
                mem_wd = v_reg[loop_cnt_reg];
            end
            ST_LD_A: mem_ra = i_reg[11:0] + 12'(loop_cnt_reg);
            ST_DR_A: mem_ra = i_reg[11:0] + 12'(loop_cnt_reg);
            default: mem_ra = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        mem_q_reg <= mem[mem_ra];
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR:    if (clr_cnt_reg == 12'(MEM_BYTES - 1)) state_next = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_func == FUNC_EXEC && !halt_reg) ? ST_F0 : ST_DONE;
                end
            end
            ST_F0:     state_next = ST_F1;
            ST_F1:     state_next = ST_F2;
            ST_F2:     state_next = ST_EXEC;
            ST_EXEC: begin
                state_next = ST_COMMIT;
                case (op_nib)
                    4'h0:    if (op_reg == OP_RET) state_next = ST_RET;
                    4'h8: begin
                        if (op_n > 4'h7 && op_n != 4'hE) state_next = ST_DONE;
                    end
                    4'hD:    state_next = ST_DR_A;
                    4'hE: begin
                        if (op_kk != 8'h9E && op_kk != 8'hA1) state_next = ST_DONE;
                    end
                    4'hF: begin
                        case (op_kk)
                            8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29: state_next = ST_COMMIT;
                            8'h33:   state_next = ST_BCD_H;
                            8'h55:   state_next = ST_ST55;
                            8'h65:   state_next = ST_LD_A;
                            default: state_next = ST_DONE;
                        endcase
                    end
                    default: state_next = ST_COMMIT;
                endcase
            end
            ST_RET:    state_next = ST_COMMIT;
            ST_BCD_H:  if (!alu_res[16]) state_next = ST_BCD_T;
            ST_BCD_T:  if (!alu_res[16]) state_next = ST_BCD_O;
            ST_BCD_O:  state_next = ST_COMMIT;
            ST_ST55:   if (loop_cnt_reg == op_x) state_next = ST_COMMIT;
            ST_LD_A:   state_next = ST_LD_D;
            ST_LD_D:   state_next = (loop_cnt_reg == op_x) ? ST_COMMIT : ST_LD_A;
            ST_DR_A:   state_next = (loop_cnt_reg == op_n) ? ST_COMMIT : ST_DR_D;
            ST_DR_D:   state_next = ST_DR_PX;
            ST_DR_PX:  if (px_reg == 3'd7) state_next = ST_DR_A;
            ST_COMMIT: state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // stack storage: registered read at the entry below the pointer
    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXEC && op_nib == 4'h2) begin
            stk_mem[sp_reg] <= pc_reg;
        end
        stk_q_reg <= stk_mem[sp_dec];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            clr_cnt_reg  <= '0;
            for (int k = 0; k < 16; k++) begin
                v_reg[k] <= '0;
            end
            for (int r = 0; r < SCREEN_ROWS; r++) begin
                fb_reg[r] <= '0;
            end
            i_reg        <= '0;
            pc_reg       <= PC_RESET;
            sp_reg       <= '0;
            dly_reg      <= '0;
            snd_reg      <= '0;
            halt_reg     <= 1'b0;
            stk_vld_reg  <= '0;
            stk_hit_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            stk_hit_reg <= stk_vld_reg[sp_dec];
            // drop the result once taken; the done state loads the next one
            if (m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLR: begin
                    clr_cnt_reg <= clr_cnt_reg + 12'd1;
                end
                ST_IDLE: begin
                    if (accept) begin
                        keys_reg     <= s_tdata[37:22];
                        wkey_reg     <= s_tdata[41:38];
                        wkey_vld_reg <= s_tdata[42];
                        rnd_reg      <= s_tdata[50:43];
                        word_reg     <= '0;
                        redraw_reg   <= 1'b0;
                        wait_reg     <= 1'b0;
                        row_out_reg  <= (s_func == FUNC_ROW) ? fb_reg[s_row_select] : '0;
                    end
                end
                ST_F1: begin
                    op_reg[15:8] <= mem_q_reg;
                end
                ST_F2: begin
                    op_reg[7:0] <= mem_q_reg;
                end
                ST_EXEC: begin
                    word_reg    <= op_reg;
                    next_pc_reg <= pc_plus2;
                    case (op_nib)
                        4'h0: begin
                            if (op_reg == OP_CLS) begin
                                for (int r = 0; r < SCREEN_ROWS; r++) begin
                                    fb_reg[r] <= '0;
                                end
                            end else if (op_reg == OP_RET) begin
                                sp_reg <= sp_dec;
                            end
                        end
                        4'h1: next_pc_reg <= op_nnn;
                        4'h2: begin
                            stk_vld_reg[sp_reg] <= 1'b1;
                            sp_reg              <= sp_inc;
                            next_pc_reg         <= op_nnn;
                        end
                        4'h3: if (vx == op_kk) next_pc_reg <= pc_plus4;
                        4'h4: if (vx != op_kk) next_pc_reg <= pc_plus4;
                        4'h5: if (vx == vy) next_pc_reg <= pc_plus4;
                        4'h6: v_reg[op_x] <= op_kk;
                        4'h7: v_reg[op_x] <= alu_res[7:0];
                        4'h8: begin
                            // the flag wins when x is VF
                            case (op_n)
                                4'h0: v_reg[op_x] <= vy;
                                4'h1: v_reg[op_x] <= vx | vy;
                                4'h2: v_reg[op_x] <= vx & vy;
                                4'h3: v_reg[op_x] <= vx ^ vy;
                                4'h4: begin
                                    if (op_x != 4'hF) v_reg[op_x] <= alu_res[7:0];
                                    v_reg[15]   <= 8'(alu_res[8]);
                                end
                                4'h5, 4'h7: begin
                                    if (op_x != 4'hF) v_reg[op_x] <= alu_res[7:0];
                                    v_reg[15]   <= 8'(alu_res[16]);
                                end
                                4'h6: begin
                                    if (op_x != 4'hF) v_reg[op_x] <= {1'b0, vx[7:1]};
                                    v_reg[15]   <= 8'(vx[0]);
                                end
                                4'hE: begin
                                    if (op_x != 4'hF) v_reg[op_x] <= {vx[6:0], 1'b0};
                                    v_reg[15]   <= 8'(vx[7]);
                                end
                                default: halt_reg <= 1'b1;
                            endcase
                        end
                        4'h9: if (vx != vy) next_pc_reg <= pc_plus4;
                        4'hA: i_reg <= 16'(op_nnn);
                        4'hB: next_pc_reg <= op_nnn + 12'(v_reg[0]);
                        4'hC: v_reg[op_x] <= rnd_reg & op_kk;
                        4'hD: begin
                            redraw_reg   <= 1'b1;
                            hit_reg      <= 1'b0;
                            loop_cnt_reg <= '0;
                        end
                        4'hE: begin
                            if (op_kk == 8'h9E) begin
                                if (key_down) next_pc_reg <= pc_plus4;
                            end else if (op_kk == 8'hA1) begin
                                if (!key_down) next_pc_reg <= pc_plus4;
                            end else begin
                                halt_reg <= 1'b1;
                            end
                        end
                        default: begin
                            case (op_kk)
                                8'h07: v_reg[op_x] <= dly_reg;
                                8'h0A: begin
                                    if (wkey_vld_reg) begin
                                        v_reg[op_x] <= 8'(wkey_reg);
                                    end else begin
                                        next_pc_reg <= pc_reg;
                                        wait_reg    <= 1'b1;
                                    end
                                end
                                8'h15: dly_reg <= vx;
                                8'h18: snd_reg <= vx;
                                8'h1E: begin
                                    i_reg     <= alu_res[15:0];
                                    v_reg[15] <= 8'(alu_res[16:12] != 5'd0);
                                end
                                8'h29: i_reg <= 16'({vx, 2'b00}) + 16'(vx);
                                8'h33: begin
                                    bcd_val_reg <= vx;
                                    digit_reg   <= '0;
                                end
                                8'h55, 8'h65: loop_cnt_reg <= '0;
                                default: halt_reg <= 1'b1;
                            endcase
                        end
                    endcase
                end
                ST_RET: begin
                    next_pc_reg <= (stk_hit_reg ? stk_q_reg : 12'd0) + 12'd2;
                end
                ST_BCD_H, ST_BCD_T: begin
                    if (alu_res[16]) begin
                        bcd_val_reg <= alu_res[7:0];
                        digit_reg   <= digit_reg + 4'd1;
                    end else begin
                        digit_reg <= '0;
                    end
                end
                ST_ST55: begin
                    loop_cnt_reg <= loop_cnt_reg + 4'd1;
                end
                ST_LD_D: begin
                    v_reg[loop_cnt_reg] <= mem_q_reg;
                    loop_cnt_reg        <= loop_cnt_reg + 4'd1;
                end
                ST_DR_A: begin
                    // flag lands after the whole sprite
                    if (loop_cnt_reg == op_n) v_reg[15] <= 8'(hit_reg);
                end
                ST_DR_D: begin
                    sprite_reg <= mem_q_reg;
                    px_reg     <= '0;
                end
                ST_DR_PX: begin
                    if (pix_on && pix_in) begin
                        if (fb_reg[pix_row][pix_bit]) hit_reg <= 1'b1;
                        fb_reg[pix_row][pix_bit] <= ~fb_reg[pix_row][pix_bit];
                    end
                    px_reg <= px_reg + 3'd1;
                    if (px_reg == 3'd7) loop_cnt_reg <= loop_cnt_reg + 4'd1;
                end
                ST_COMMIT: begin
                    pc_reg <= next_pc_reg;
                    if (dly_reg != 8'd0) dly_reg <= dly_reg - 8'd1;
                    if (snd_reg != 8'd0) snd_reg <= snd_reg - 8'd1;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {row_out_reg, wait_reg, halt_reg,
                                         (snd_reg != 8'd0), redraw_reg, word_reg, pc_reg};
                    end
                end
                default: begin
                    clr_cnt_reg <= clr_cnt_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("request accepted while another is in work");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> halt_reg)
        else $error("halt flag dropped without reset");

    a_halt_holds_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg && $past(halt_reg) |-> $stable(pc_reg))
        else $error("program counter moved while halted");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> m_tvalid_reg && $stable(m_tdata_reg))
        else $error("pending result overwritten");

    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLR) |-> !s_tready)
        else $error("request taken during memory clear");

endmodule

`default_nettype wire
